/* design/bedp_pkg.sv */
// ----------------------------------------------------------------------------
// bedp_pkg
// Shared types and constants for the block edge DPCM predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package bedp_pkg;

    localparam int BLOCK_DEF     = 4;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int SAMPLE_W   = 11;
    localparam int RESULT_W   = 12;
    localparam int CODE_W     = 2;
    localparam int LW_W       = 11;
    localparam int ROW_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [LW_W-1:0] LINE_WIDTH_RST = 11'd1024;

    // predictor codes
    localparam logic [CODE_W-1:0] STRAT_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] STRAT_ABOVE = 2'd1;
    localparam logic [CODE_W-1:0] STRAT_LEFT  = 2'd2;
    localparam logic [CODE_W-1:0] STRAT_RSVD  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'd1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [CODE_W-1:0]          strategy_in;
        logic                       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [RESULT_W-1:0] result_value;
        logic [CODE_W-1:0]          strategy_out;
    } t_out_item;

    // where the current pixel sits inside its block and the frame
    typedef struct packed {
        logic has_above;
        logic has_left;
        logic is_edge;
        logic is_corner;
    } t_pos_flags;

endpackage

`default_nettype wire

/* design/bedp_pos.sv */
// ----------------------------------------------------------------------------
// bedp_pos
// Raster position tracker: row/column counters, block phase and the
// history and choice store addresses of the pixel being accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module bedp_pos #(
    parameter int BLOCK     = bedp_pkg::BLOCK_DEF,
    parameter int MAX_WIDTH = bedp_pkg::MAX_WIDTH_DEF,
    localparam int CW       = $clog2(MAX_WIDTH),
    localparam int RMW      = $clog2(BLOCK),
    localparam int CDEPTH   = (MAX_WIDTH + BLOCK - 1) / BLOCK,
    localparam int BW       = (CDEPTH > 1) ? $clog2(CDEPTH) : 1,
    localparam int HAW      = $clog2(BLOCK * MAX_WIDTH)
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic                        i_frame_start,
    input  wire logic [bedp_pkg::LW_W-1:0]   i_line_width,
    output bedp_pkg::t_pos_flags             o_flags,
    output logic [HAW-1:0]                   o_hist_addr,
    output logic [HAW-1:0]                   o_left_addr,
    output logic [BW-1:0]                    o_blk_idx
);

    localparam int CMPW = ((CW + 1) > 12) ? (CW + 1) : 12;
    localparam logic [CMPW-1:0] MW_C   = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] BLK_C  = CMPW'(BLOCK);
    localparam logic [HAW-1:0]  MW_H   = HAW'(MAX_WIDTH);
    localparam logic [HAW-1:0]  BLK_H  = HAW'(BLOCK);
    localparam logic [RMW-1:0]  PH_MAX = RMW'(BLOCK - 1);
    localparam logic [bedp_pkg::ROW_W-1:0] ROW_MAX = '1;

    logic [bedp_pkg::ROW_W-1:0] r_row, n_row, cur_row;
    logic [RMW-1:0]             r_row_mod, n_row_mod, cur_row_mod;
    logic [CW-1:0]              r_col, n_col, cur_col;
    logic [RMW-1:0]             r_col_mod, n_col_mod, cur_col_mod;
    logic [BW-1:0]              r_blk, n_blk, cur_blk;

    logic [CMPW-1:0] lw_ext;
    logic [CMPW-1:0] width_eff;
    logic [CMPW-1:0] col_inc;
    logic            wrap;
    logic [HAW-1:0]  base_addr;

    // a frame start puts this pixel at the origin
    assign cur_row     = i_frame_start ? '0 : r_row;
    assign cur_row_mod = i_frame_start ? '0 : r_row_mod;
    assign cur_col     = i_frame_start ? '0 : r_col;
    assign cur_col_mod = i_frame_start ? '0 : r_col_mod;
    assign cur_blk     = i_frame_start ? '0 : r_blk;

    assign lw_ext    = CMPW'(i_line_width);
    assign width_eff = (lw_ext == '0 || lw_ext > MW_C) ? MW_C : lw_ext;
    assign col_inc   = CMPW'(cur_col) + CMPW'(1);
    assign wrap      = (col_inc >= width_eff);

    assign o_flags.has_above = (cur_row >= bedp_pkg::ROW_W'(BLOCK));
    assign o_flags.has_left  = (CMPW'(cur_col) >= BLK_C);
    assign o_flags.is_edge   = (cur_row_mod == '0) || (cur_col_mod == '0);
    assign o_flags.is_corner = (cur_row_mod == '0) && (cur_col_mod == '0);

    assign base_addr   = HAW'(cur_row_mod) * MW_H;
    assign o_hist_addr = base_addr + HAW'(cur_col);
    assign o_left_addr = o_hist_addr - BLK_H;
    assign o_blk_idx   = cur_blk;

    always_comb begin
        n_row     = cur_row;
        n_row_mod = cur_row_mod;
        n_col     = cur_col;
        n_col_mod = cur_col_mod;
        n_blk     = cur_blk;
        if (wrap) begin
            n_col     = '0;
            n_col_mod = '0;
            n_blk     = '0;
            n_row     = cur_row + 1'b1;
            // row phase restarts at each block boundary and when the 16-bit row counter wraps
            if (cur_row == ROW_MAX || cur_row_mod == PH_MAX) begin
                n_row_mod = '0;
            end else begin
                n_row_mod = cur_row_mod + 1'b1;
            end
        end else begin
            n_col = col_inc[CW-1:0];
            if (cur_col_mod == PH_MAX) begin
                n_col_mod = '0;
                n_blk     = cur_blk + 1'b1;
            end else begin
                n_col_mod = cur_col_mod + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row     <= '0;
            r_row_mod <= '0;
            r_col     <= '0;
            r_col_mod <= '0;
            r_blk     <= '0;
        end else if (i_adv) begin
            r_row     <= n_row;
            r_row_mod <= n_row_mod;
            r_col     <= n_col;
            r_col_mod <= n_col_mod;
            r_blk     <= n_blk;
        end
    end

endmodule

`default_nettype wire

/* design/bedp_hist.sv */
// ----------------------------------------------------------------------------
// bedp_hist
// Pixel history RAM: one write port, two registered read ports, with
// write-to-read forwarding for a same-edge collision.
// ----------------------------------------------------------------------------
`default_nettype none

module bedp_hist #(
    parameter int DEPTH = bedp_pkg::BLOCK_DEF * bedp_pkg::MAX_WIDTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int DW   = bedp_pkg::RESULT_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr_a,
    input  wire logic [AW-1:0] i_rd_addr_b,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    output logic [DW-1:0]      o_rd_data_a,
    output logic [DW-1:0]      o_rd_data_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= (i_wr_en && i_wr_addr == i_rd_addr_a) ? i_wr_data : r_mem[i_rd_addr_a];
            r_rd_b <= (i_wr_en && i_wr_addr == i_rd_addr_b) ? i_wr_data : r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

`default_nettype wire

/* design/bedp_choice.sv */
// ----------------------------------------------------------------------------
// bedp_choice
// Per block column corner choice RAM: one write port, one registered read
// port, with forwarding when the corner and its neighbor hit one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module bedp_choice #(
    parameter int DEPTH = (bedp_pkg::MAX_WIDTH_DEF + bedp_pkg::BLOCK_DEF - 1)
                          / bedp_pkg::BLOCK_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int DW   = bedp_pkg::CODE_W
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    output logic [DW-1:0]      o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= (i_wr_en && i_wr_addr == i_rd_addr) ? i_wr_data : r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

`default_nettype wire

/* design/block_edge_dpcm_predictor_core.sv */
// ----------------------------------------------------------------------------
// block_edge_dpcm_predictor_core
// Block edge DPCM predictor / reconstructor over a raster pixel stream.
//
// Input channel i_valid/o_stall carries one pixel (forward) or residual
// (inverse) per transaction, with the inverse predictor code and a frame
// start mark. Output channel o_valid/i_stall carries the residual or rebuilt
// pixel, saturated to 12 bits, and the code used. One result per input.
// Throughput: one transaction per clock while i_stall is low, set by the single
// write port of the history RAM that every pixel updates. The RAMs are read at
// the accepting edge into the compute stage, and the result is computed into
// the output register when the compute stage advances.
// Config: i_cfg_we writes line_width (index 0) or direction (index 1) at the
// clock edge; write only while no transaction is in flight.
// Reset (synchronous, i_rst_n low) clears the pipeline and position
// counters and sets line_width to 1024, direction to forward. The RAMs are
// not cleared; a frame must start before history is referenced.
// When i_stall is high the output holds, the compute stage holds one more
// transaction, and o_stall rises only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module block_edge_dpcm_predictor_core #(
    parameter int BLOCK     = bedp_pkg::BLOCK_DEF,
    parameter int MAX_WIDTH = bedp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire bedp_pkg::t_in_item                i_data,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output bedp_pkg::t_out_item                    o_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [bedp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [bedp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int HDEPTH = BLOCK * MAX_WIDTH;
    localparam int CDEPTH = (MAX_WIDTH + BLOCK - 1) / BLOCK;
    localparam int HAW    = $clog2(HDEPTH);
    localparam int BW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;
    localparam int SW     = bedp_pkg::SAMPLE_W;
    localparam int RW     = bedp_pkg::RESULT_W;
    localparam int CDW    = bedp_pkg::CODE_W;
    localparam int XW     = RW + 1;

    localparam logic signed [XW-1:0] SAT_HI = XW'(2047);
    localparam logic signed [XW-1:0] SAT_LO = -XW'(2048);

    function automatic logic signed [RW-1:0] sat_res(input logic signed [XW-1:0] v);
        logic signed [RW-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[RW-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[RW-1:0];
        end else begin
            r = v[RW-1:0];
        end
        return r;
    endfunction

    // configuration
    logic [bedp_pkg::LW_W-1:0] r_line_width;
    logic                      r_direction;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= bedp_pkg::LINE_WIDTH_RST;
            r_direction  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bedp_pkg::REG_LINE_WIDTH: r_line_width <= i_cfg_data;
                bedp_pkg::REG_DIRECTION:  r_direction  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // handshake
    logic r_s1_valid;
    logic r_o_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv  = r_s1_valid && (!r_o_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_adv;
    assign in_acc  = i_valid && !o_stall;

    // position and addresses of the pixel being accepted
    bedp_pkg::t_pos_flags pos_flags;
    logic [HAW-1:0]       hist_addr;
    logic [HAW-1:0]       left_addr;
    logic [BW-1:0]        blk_idx;

    bedp_pos #(
        .BLOCK     (BLOCK),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (in_acc),
        .i_frame_start (i_data.frame_start),
        .i_line_width  (r_line_width),
        .o_flags       (pos_flags),
        .o_hist_addr   (hist_addr),
        .o_left_addr   (left_addr),
        .o_blk_idx     (blk_idx)
    );

    // compute stage registers
    logic signed [SW-1:0] r_s1_x;
    logic [CDW-1:0]       r_s1_code_in;
    bedp_pkg::t_pos_flags r_s1_flags;
    logic [HAW-1:0]       r_s1_haddr;
    logic [BW-1:0]        r_s1_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_x       <= i_data.sample_value;
            r_s1_code_in <= i_data.strategy_in;
            r_s1_flags   <= pos_flags;
            r_s1_haddr   <= hist_addr;
            r_s1_blk     <= blk_idx;
        end
    end

    // stores
    logic [RW-1:0]  above_q;
    logic [RW-1:0]  left_q;
    logic [CDW-1:0] choice_q;
    logic [RW-1:0]  hist_wdata;
    logic           choice_we;
    logic [CDW-1:0] code;

    bedp_hist #(
        .DEPTH (HDEPTH)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rd_en     (in_acc),
        .i_rd_addr_a (hist_addr),
        .i_rd_addr_b (left_addr),
        .i_wr_en     (s1_adv),
        .i_wr_addr   (r_s1_haddr),
        .i_wr_data   (hist_wdata),
        .o_rd_data_a (above_q),
        .o_rd_data_b (left_q)
    );

    bedp_choice #(
        .DEPTH (CDEPTH)
    ) u_choice (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (blk_idx),
        .i_wr_en   (choice_we),
        .i_wr_addr (r_s1_blk),
        .i_wr_data (code),
        .o_rd_data (choice_q)
    );

    // prediction
    logic signed [XW-1:0] x_e;
    logic signed [XW-1:0] above_e;
    logic signed [XW-1:0] left_e;
    logic signed [XW-1:0] diff_a;
    logic signed [XW-1:0] diff_l;
    logic [XW-1:0]        abs_a;
    logic [XW-1:0]        abs_l;
    logic signed [XW-1:0] nb;
    logic signed [XW-1:0] sum;
    logic signed [RW-1:0] res;
    logic                 active;

    assign x_e     = XW'(r_s1_x);
    assign above_e = {above_q[RW-1], above_q};
    assign left_e  = {left_q[RW-1], left_q};
    assign diff_a  = x_e - above_e;
    assign diff_l  = x_e - left_e;
    assign abs_a   = diff_a[XW-1] ? XW'(-diff_a) : XW'(diff_a);
    assign abs_l   = diff_l[XW-1] ? XW'(-diff_l) : XW'(diff_l);

    // first block of the frame has neither neighbor
    assign active = r_s1_flags.is_edge && (r_s1_flags.has_above || r_s1_flags.has_left);

    always_comb begin
        code = bedp_pkg::STRAT_NONE;
        if (active) begin
            if (!r_direction) begin
                if (r_s1_flags.is_corner) begin
                    if (!r_s1_flags.has_left || (r_s1_flags.has_above && abs_a <= abs_l)) begin
                        code = bedp_pkg::STRAT_ABOVE;
                    end else begin
                        code = bedp_pkg::STRAT_LEFT;
                    end
                end else if (choice_q != bedp_pkg::STRAT_RSVD) begin
                    code = choice_q;
                end
            end else if (r_s1_code_in != bedp_pkg::STRAT_RSVD) begin
                code = r_s1_code_in;
            end
        end
    end

    // a missing neighbor reads as the input value itself
    always_comb begin
        if (code == bedp_pkg::STRAT_ABOVE) begin
            nb = r_s1_flags.has_above ? above_e : x_e;
        end else begin
            nb = r_s1_flags.has_left ? left_e : x_e;
        end
        if (code == bedp_pkg::STRAT_NONE) begin
            sum = x_e;
        end else if (r_direction) begin
            sum = x_e + nb;
        end else begin
            sum = x_e - nb;
        end
    end

    assign res        = sat_res(sum);
    assign hist_wdata = r_direction ? res : x_e[RW-1:0];
    assign choice_we  = s1_adv && !r_direction && r_s1_flags.is_corner && active;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_data.result_value <= res;
            o_data.strategy_out <= code;
        end
    end

    assign o_valid = r_o_valid;

    // checks
    a_code_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> o_data.strategy_out != bedp_pkg::STRAT_RSVD)
        else $error("reserved predictor code on output");

    a_frame_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_data.frame_start) |=>
            (r_s1_valid && !r_s1_flags.has_above && !r_s1_flags.has_left))
        else $error("frame start did not reset position");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_haddr)))
        else $error("held transaction lost in compute stage");

    a_pass_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && !r_s1_flags.has_above && !r_s1_flags.has_left) |=>
            (o_data.strategy_out == bedp_pkg::STRAT_NONE))
        else $error("first block pixel was predicted");

endmodule

`default_nettype wire
